### rtl/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback scheduler arithmetic unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mlfq_pkg;

   // Field widths
   localparam int WORD_WIDTH      = 32;
   localparam int OP_WIDTH        = 2;
   localparam int NICE_WIDTH      = 6;
   localparam int READY_WIDTH     = 7;
   localparam int PRI_WIDTH       = 6;
   localparam int REQ_TDATA_WIDTH = 48;
   localparam int RSP_TDATA_WIDTH = 72;

   // Lowest legal priority (fixed)
   localparam int PRIORITY_MIN = 0;

   // Operation codes
   localparam logic [OP_WIDTH-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_RECENT = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_PRIO   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD_MUL,
      ST_LOAD_SUM,
      ST_DIV_WAIT,
      ST_RC_MUL,
      ST_RC_SUM,
      ST_PRIO_SUB,
      ST_PRIO_CLAMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul_load;
      logic set_load;
      logic div_start;
      logic mul_rc;
      logic set_nrc;
      logic prio_sub;
      logic set_pri;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic                div_done;
   } status_type;

endpackage

`default_nettype wire

### rtl/mlfq_div.sv
// Iterative restoring divider: trunc((num * 2^FRACTION_BITS) / den), low 32 bits.
// One quotient bit per cycle; depends on mlfq_pkg.
`default_nettype none

module mlfq_div
   import mlfq_pkg::*;
#(
   parameter int FRACTION_BITS = 14
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [WORD_WIDTH-1:0] num,
   input  wire logic signed [WORD_WIDTH-1:0] den,
   output logic                              done,
   output logic signed [WORD_WIDTH-1:0]      quotient
);

   localparam int NW = WORD_WIDTH + FRACTION_BITS;
   localparam int CW = $clog2(NW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]     shift_ff, shift_in;
   logic [WORD_WIDTH:0] rem_ff, rem_in;
   logic [WORD_WIDTH-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic [WORD_WIDTH-1:0] q_ff, q_in;

   logic [WORD_WIDTH-1:0] num_mag;
   logic [WORD_WIDTH:0]   rem_sh;
   logic                  ge;
   logic [NW-1:0]         shift_next;
   logic [WORD_WIDTH-1:0] qmag;

   always_comb begin
      num_mag    = num[WORD_WIDTH-1] ? -num : num;
      rem_sh     = {rem_ff[WORD_WIDTH-1:0], shift_ff[NW-1]};
      ge         = rem_sh >= {1'b0, dmag_ff};
      shift_next = {shift_ff[NW-2:0], ge};
      qmag       = shift_next[WORD_WIDTH-1:0];

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      q_in     = q_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = {num_mag, {FRACTION_BITS{1'b0}}};
         rem_in   = '0;
         dmag_in  = den[WORD_WIDTH-1] ? -den : den;
         neg_in   = num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
         zero_in  = (den == '0);
      end else if (busy_ff) begin
         shift_in = shift_next;
         rem_in   = ge ? (rem_sh - {1'b0, dmag_ff}) : rem_sh;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (zero_ff) begin
               q_in = '0;
            end else begin
               q_in = neg_ff ? -qmag : qmag;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dmag_ff  <= dmag_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      q_ff     <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

### rtl/mlfq_dp.sv
// Datapath: operand registers, load average, multiplier, adders, clamp, result register.
// Depends on mlfq_pkg and mlfq_div.
`default_nettype none

module mlfq_dp
   import mlfq_pkg::*;
#(
   parameter int FRACTION_BITS = 14,
   parameter int PRIORITY_MAX  = 63
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic [OP_WIDTH-1:0]        req_op,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_data,
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_data
);

   localparam int ONE_INT = 1 << FRACTION_BITS;
   localparam int C59_INT = (59 * ONE_INT) / 60;
   localparam int C1_INT  = ONE_INT / 60;
   localparam logic signed [WORD_WIDTH-1:0]   ONE32   = WORD_WIDTH'(ONE_INT);
   localparam logic signed [WORD_WIDTH-1:0]   ROUND32 = WORD_WIDTH'(ONE_INT - 1);
   localparam logic signed [2*WORD_WIDTH-1:0] ROUND64 = (2*WORD_WIDTH)'(ONE_INT - 1);
   localparam logic signed [WORD_WIDTH-1:0]   C59     = WORD_WIDTH'(C59_INT);
   localparam logic [WORD_WIDTH-1:0]          C1      = WORD_WIDTH'(C1_INT);
   localparam logic signed [WORD_WIDTH-1:0]   PMAX_F  = WORD_WIDTH'(PRIORITY_MAX * ONE_INT);
   localparam logic signed [WORD_WIDTH-1:0]   PMAX32  = WORD_WIDTH'(PRIORITY_MAX);
   localparam logic signed [WORD_WIDTH-1:0]   PMIN32  = WORD_WIDTH'(PRIORITY_MIN);
   localparam int PAD_WIDTH = RSP_TDATA_WIDTH - 2*WORD_WIDTH - PRI_WIDTH;

   logic [OP_WIDTH-1:0]              op_ff;
   logic signed [WORD_WIDTH-1:0]     rc_ff;
   logic signed [NICE_WIDTH-1:0]     nice_ff;
   logic [READY_WIDTH-1:0]           ready_ff;
   logic signed [WORD_WIDTH-1:0]     load_ff, load_in;
   logic signed [2*WORD_WIDTH-1:0]   prod_ff, prod_in;
   logic signed [WORD_WIDTH-1:0]     f_ff;
   logic signed [WORD_WIDTH-1:0]     nrc_ff, nrc_in;
   logic [PRI_WIDTH-1:0]             pri_ff, pri_in;
   logic [RSP_TDATA_WIDTH-1:0]       out_ff;

   logic signed [WORD_WIDTH-1:0]     num_w, den_w;
   logic                             div_done;
   logic signed [WORD_WIDTH-1:0]     div_q;
   logic signed [2*WORD_WIDTH-1:0]   prod_adj, prod_sh;
   logic signed [WORD_WIDTH-1:0]     prod_lo;
   logic [WORD_WIDTH-1:0]            ready_term;
   logic signed [WORD_WIDTH-1:0]     nice32, nice_f, nice_f2;
   logic signed [WORD_WIDTH-1:0]     rc_adj, rc_q, f_in;
   logic signed [WORD_WIDTH-1:0]     f_adj, pr, pr_clamp;

   // 2*load and 2*load + F, both wrapping
   assign num_w = {load_ff[WORD_WIDTH-2:0], 1'b0};
   assign den_w = num_w + ONE32;

   mlfq_div #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num     (num_w),
      .den     (den_w),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      // product / F, truncated toward zero
      prod_adj   = prod_ff + (prod_ff[2*WORD_WIDTH-1] ? ROUND64 : 64'sd0);
      prod_sh    = prod_adj >>> FRACTION_BITS;
      prod_lo    = prod_sh[WORD_WIDTH-1:0];
      ready_term = C1 * WORD_WIDTH'(ready_ff);

      nice32  = WORD_WIDTH'(nice_ff);
      nice_f  = nice32 <<< FRACTION_BITS;
      nice_f2 = nice32 <<< (FRACTION_BITS + 1);

      rc_adj = rc_ff + (rc_ff[WORD_WIDTH-1] ? 32'sd3 : 32'sd0);
      rc_q   = rc_adj >>> 2;
      f_in   = PMAX_F - rc_q - nice_f2;

      f_adj = f_ff + (f_ff[WORD_WIDTH-1] ? ROUND32 : 32'sd0);
      pr    = f_adj >>> FRACTION_BITS;
      if (pr > PMAX32) begin
         pr_clamp = PMAX32;
      end else if (pr < PMIN32) begin
         pr_clamp = PMIN32;
      end else begin
         pr_clamp = pr;
      end

      // 32 x 32 signed products, operands sign-extended to the product width
      prod_in = prod_ff;
      if (cmd.mul_load) begin
         prod_in = (2*WORD_WIDTH)'(C59) * (2*WORD_WIDTH)'(load_ff);
      end else if (cmd.mul_rc) begin
         prod_in = (2*WORD_WIDTH)'(div_q) * (2*WORD_WIDTH)'(rc_ff);
      end

      load_in = cmd.set_load ? (prod_lo + $signed(ready_term)) : load_ff;

      nrc_in = nrc_ff;
      pri_in = pri_ff;
      if (cmd.capture) begin
         nrc_in = '0;
         pri_in = '0;
      end else begin
         if (cmd.set_nrc) begin
            nrc_in = prod_lo + nice_f;
         end
         if (cmd.set_pri) begin
            pri_in = pr_clamp[PRI_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         rc_ff    <= req_data[WORD_WIDTH-1:0];
         nice_ff  <= req_data[WORD_WIDTH +: NICE_WIDTH];
         ready_ff <= req_data[WORD_WIDTH + NICE_WIDTH +: READY_WIDTH];
      end
      if (cmd.prio_sub) begin
         f_ff <= f_in;
      end
      if (cmd.publish) begin
         out_ff <= {{PAD_WIDTH{1'b0}}, load_ff, pri_ff, nrc_ff};
      end
      prod_ff <= prod_in;
      nrc_ff  <= nrc_in;
      pri_ff  <= pri_in;
   end

   assign status.op       = op_ff;
   assign status.div_done = div_done;
   assign rsp_data        = out_ff;

endmodule

`default_nettype wire

### rtl/mlfq_ctrl.sv
// Controller: sequences one item through the datapath and owns both handshakes.
// Depends on mlfq_pkg.
`default_nettype none

module mlfq_ctrl
   import mlfq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_publish;

   assign can_publish = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_LOAD:   state_in = ST_LOAD_MUL;
               OP_RECENT: state_in = ST_DIV_WAIT;
               OP_PRIO:   state_in = ST_PRIO_SUB;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_LOAD_MUL:   state_in = ST_LOAD_SUM;
         ST_LOAD_SUM:   state_in = ST_FINISH;
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_RC_MUL;
         end
         ST_RC_MUL:     state_in = ST_RC_SUM;
         ST_RC_SUM:     state_in = ST_FINISH;
         ST_PRIO_SUB:   state_in = ST_PRIO_CLAMP;
         ST_PRIO_CLAMP: state_in = ST_FINISH;
         ST_FINISH: begin
            if (can_publish) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs; no input transfer while reset is held
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
         end
         ST_DISPATCH:   cmd.div_start = (status.op == OP_RECENT);
         ST_LOAD_MUL:   cmd.mul_load  = 1'b1;
         ST_LOAD_SUM:   cmd.set_load  = 1'b1;
         ST_DIV_WAIT:   cmd.mul_rc    = 1'b0;
         ST_RC_MUL:     cmd.mul_rc    = 1'b1;
         ST_RC_SUM:     cmd.set_nrc   = 1'b1;
         ST_PRIO_SUB:   cmd.prio_sub  = 1'b1;
         ST_PRIO_CLAMP: cmd.set_pri   = 1'b1;
         ST_FINISH:     cmd.publish   = can_publish;
         default:       cmd           = '0;
      endcase
   end

   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/mlfq_priority_load_update_core.sv
// Top level of the multilevel feedback scheduler arithmetic unit.
// Depends on mlfq_pkg, mlfq_ctrl, mlfq_dp (which holds mlfq_div).
//
// Fixed-point helper for a 4.4BSD-style scheduler. Values are signed 32-bit with
// FRACTION_BITS fraction bits. The block holds the system load average (zero after
// reset). The op code on req_tuser picks the work: op 0 folds ready_count into the
// load average, op 1 recomputes a thread's recent cpu from the current load average,
// op 2 computes the thread's priority clamped to 0..PRIORITY_MAX (masked to 6 bits);
// op 3 only reports the load average. Every transfer in gives exactly one transfer
// out, carrying the load average after the item; fields that do not belong to the op
// read zero. Items are handled one at a time. Op 0 multiplies and then sums, op 2
// subtracts and then clamps, op 3 goes straight to the result, and op 1 first waits
// for the iterative divider, which produces one quotient bit per cycle, and then
// multiplies and sums. A finished result sits in an output register, so the next
// input transfer is taken while the previous result still waits for rsp_tready.
// req_tready stays low while reset is held.
`default_nettype none

module mlfq_priority_load_update_core
   import mlfq_pkg::*;
#(
   parameter int FRACTION_BITS = 14,
   parameter int PRIORITY_MAX  = 63
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // [31:0] recent_cpu, [37:32] nice_value, [44:38] ready_count, rest zero
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // [1:0] op
   input  wire logic [OP_WIDTH-1:0]        req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [31:0] new_recent_cpu, [37:32] priority_res, [69:38] load_average, rest zero
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one item at a time, owns tready/tvalid
   mlfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, load average register and result register
   mlfq_dp #(
      .FRACTION_BITS(FRACTION_BITS),
      .PRIORITY_MAX (PRIORITY_MAX)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .req_op  (req_tuser),
      .req_data(req_tdata),
      .rsp_data(rsp_tdata)
   );

endmodule

`default_nettype wire
